// ===== rtl/core/owf_pkg.sv =====
`default_nettype none

package owf_pkg;

    // Default geometry
    localparam int DEFAULT_DEPTH        = 64;
    localparam int DEFAULT_SAMPLE_WIDTH = 32;

    // Fixed field widths of the item and result channels
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LEVEL_W  = 7;
    localparam int TOTAL_W  = 32;

    // Operation codes
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

    // What the control unit decided for the item being accepted
    typedef struct packed {
        logic push;
        logic pop_hit;
        logic pop_miss;
        logic overflow;
    } t_op_flags;

endpackage

`default_nettype wire

// ===== rtl/core/owf_store.sv =====
`default_nettype none

module owf_store #(
    parameter int DEPTH        = owf_pkg::DEFAULT_DEPTH,
    parameter int SAMPLE_WIDTH = owf_pkg::DEFAULT_SAMPLE_WIDTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [SAMPLE_WIDTH-1:0]  i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [SAMPLE_WIDTH-1:0]  o_rd_data
);

    logic [SAMPLE_WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read; holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/owf_ctrl.sv =====
`default_nettype none

module owf_ctrl #(
    parameter int DEPTH = owf_pkg::DEFAULT_DEPTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic                         i_kind,
    output owf_pkg::t_op_flags                o_flags,
    output logic [$clog2(DEPTH)-1:0]          o_wr_ptr,
    output logic [$clog2(DEPTH)-1:0]          o_rd_ptr,
    output logic [$clog2(DEPTH+1)-1:0]        o_held,
    output logic [$clog2(DEPTH+1)-1:0]        o_peak,
    output logic [owf_pkg::TOTAL_W-1:0]       o_pushes,
    output logic [owf_pkg::TOTAL_W-1:0]       o_pops,
    output logic [owf_pkg::TOTAL_W-1:0]       o_drops
);

    import owf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_held,   n_held;
    logic [CNT_W-1:0]   r_peak,   n_peak;
    logic [TOTAL_W-1:0] r_pushes, n_pushes;
    logic [TOTAL_W-1:0] r_pops,   n_pops;
    logic [TOTAL_W-1:0] r_drops,  n_drops;
    logic               full;
    logic               empty;
    logic [PTR_W-1:0]   wr_ptr_inc;
    logic [PTR_W-1:0]   rd_ptr_inc;

    assign full  = (r_held == FULL_CNT);
    assign empty = (r_held == '0);

    assign wr_ptr_inc = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
    assign rd_ptr_inc = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);

    always_comb begin
        o_flags.push     = i_accept && (i_kind == KIND_PUSH);
        o_flags.overflow = o_flags.push && full;
        o_flags.pop_hit  = i_accept && (i_kind == KIND_POP) && !empty;
        o_flags.pop_miss = i_accept && (i_kind == KIND_POP) && empty;
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_held   = r_held;
        n_peak   = r_peak;
        n_pushes = r_pushes;
        n_pops   = r_pops;
        n_drops  = r_drops;
        if (o_flags.push) begin
            n_wr_ptr = wr_ptr_inc;
            n_pushes = r_pushes + TOTAL_W'(1);
            if (full) begin
                // drop the oldest, level stays at full
                n_rd_ptr = rd_ptr_inc;
                n_drops  = r_drops + TOTAL_W'(1);
            end else begin
                n_held = r_held + CNT_W'(1);
            end
            if (n_held > r_peak) begin
                n_peak = n_held;
            end
        end else if (o_flags.pop_hit) begin
            n_rd_ptr = rd_ptr_inc;
            n_held   = r_held - CNT_W'(1);
            n_pops   = r_pops + TOTAL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_held   <= '0;
            r_peak   <= '0;
            r_pushes <= '0;
            r_pops   <= '0;
            r_drops  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_held   <= n_held;
            r_peak   <= n_peak;
            r_pushes <= n_pushes;
            r_pops   <= n_pops;
            r_drops  <= n_drops;
        end
    end

    assign o_wr_ptr = r_wr_ptr;
    assign o_rd_ptr = r_rd_ptr;
    assign o_held   = r_held;
    assign o_peak   = r_peak;
    assign o_pushes = r_pushes;
    assign o_pops   = r_pops;
    assign o_drops  = r_drops;

endmodule

`default_nettype wire

// ===== rtl/core/overwrite_oldest_fifo_with_stats.sv =====
// Overwrite-oldest sample FIFO with running statistics. Each item is a push
// or a pop and yields exactly one result, in the cycle after the item is taken.
// The block takes one item per clock cycle, sustained, as long as the result
// side keeps up: the result register frees in the same cycle it is taken, so
// ready stays high through back-to-back traffic. The sample store is a
// single-write, single-read memory with a registered read port; a push writes
// and a pop reads in the cycle the item is taken, so a pop may directly follow
// the push that filled its entry. The store is not cleared after reset and
// needs no clearing pass; only written entries are ever read. A push into a
// full buffer drops the oldest sample and reports overflow; a pop from an
// empty buffer reports empty with zero data and leaves the state alone. The
// fill and peak levels and the push, pop and drop totals are the state as it
// stands after the item; the totals wrap at 32 bits.
`default_nettype none

module overwrite_oldest_fifo_with_stats #(
    parameter int DEPTH        = owf_pkg::DEFAULT_DEPTH,
    parameter int SAMPLE_WIDTH = owf_pkg::DEFAULT_SAMPLE_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // item channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_kind,
    input  wire logic [owf_pkg::DATA_W-1:0]    i_push_data,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [owf_pkg::STATUS_W-1:0]       o_status,
    output logic [owf_pkg::DATA_W-1:0]         o_pop_data,
    output logic [owf_pkg::LEVEL_W-1:0]        o_fill_level,
    output logic [owf_pkg::LEVEL_W-1:0]        o_peak_level,
    output logic [owf_pkg::TOTAL_W-1:0]        o_pushes_total,
    output logic [owf_pkg::TOTAL_W-1:0]        o_pops_total,
    output logic [owf_pkg::TOTAL_W-1:0]        o_drops_total
);

    import owf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                    accept;
    t_op_flags               flags;
    logic [PTR_W-1:0]        wr_ptr;
    logic [PTR_W-1:0]        rd_ptr;
    logic [CNT_W-1:0]        held;
    logic [CNT_W-1:0]        peak;
    logic [SAMPLE_WIDTH-1:0] wr_sample;
    logic [SAMPLE_WIDTH-1:0] rd_sample;

    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_status, n_status;
    logic                    r_pop_hit;

    // The result register frees when its item is taken in the same cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    owf_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_kind   (i_kind),
        .o_flags  (flags),
        .o_wr_ptr (wr_ptr),
        .o_rd_ptr (rd_ptr),
        .o_held   (held),
        .o_peak   (peak),
        .o_pushes (o_pushes_total),
        .o_pops   (o_pops_total),
        .o_drops  (o_drops_total)
    );

    // Keep the low SAMPLE_WIDTH bits of the pushed word; zero-fill if wider.
    assign wr_sample = SAMPLE_WIDTH'(64'(i_push_data));

    owf_store #(
        .DEPTH        (DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (flags.push),
        .i_wr_addr (wr_ptr),
        .i_wr_data (wr_sample),
        .i_rd_en   (flags.pop_hit),
        .i_rd_addr (rd_ptr),
        .o_rd_data (rd_sample)
    );

    always_comb begin
        priority if (flags.overflow) begin
            n_status = ST_OVERFLOW;
        end else if (flags.pop_miss) begin
            n_status = ST_EMPTY;
        end else begin
            n_status = ST_OK;
        end
    end

    // Result register: valid, status and the pop-hit mark; the popped word
    // sits in the store's read register and the statistics in the control
    // state, both of which change only when an item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pop_hit   <= 1'b0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
                r_pop_hit   <= flags.pop_hit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    // drive zero unless the item popped a sample
    assign o_pop_data   = r_pop_hit ? DATA_W'(64'(rd_sample)) : '0;
    assign o_fill_level = LEVEL_W'(held);
    assign o_peak_level = LEVEL_W'(peak);

endmodule

`default_nettype wire

// ===== rtl/core/owf_checker.sv =====
`default_nettype none

module owf_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic                          i_kind,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [owf_pkg::STATUS_W-1:0]  o_status,
    input wire logic [owf_pkg::DATA_W-1:0]    o_pop_data,
    input wire logic [owf_pkg::LEVEL_W-1:0]   o_fill_level,
    input wire logic [owf_pkg::LEVEL_W-1:0]   o_peak_level,
    input wire logic [owf_pkg::TOTAL_W-1:0]   o_pushes_total,
    input wire logic [owf_pkg::TOTAL_W-1:0]   o_drops_total
);

    import owf_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // A stalled result holds.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_pop_data))
        else $error("stalled result changed");

    // An empty pop returns zero data from an empty buffer.
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |->
            o_pop_data == '0 && o_fill_level == '0)
        else $error("empty pop with data or nonzero level");

    // Every push advances the push total by one in its result.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_kind == KIND_PUSH |=>
            o_out_valid && o_pushes_total == $past(o_pushes_total) + TOTAL_W'(1))
        else $error("push total did not advance");

    // An overflow drops exactly one sample and leaves the buffer at its peak.
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_status != ST_OVERFLOW ||
            (o_drops_total == $past(o_drops_total) + TOTAL_W'(1) &&
             o_fill_level == o_peak_level))
        else $error("overflow result inconsistent");

    // A taken item always yields a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("accepted item produced no result");

endmodule

bind overwrite_oldest_fifo_with_stats owf_checker u_owf_checker (.*);

`default_nettype wire

// ===== verif/tb_overwrite_oldest_fifo_with_stats.sv =====
`timescale 1ns / 1ps

module tb_overwrite_oldest_fifo_with_stats;
    import owf_pkg::*;

    localparam int FIFO_DEPTH = DEFAULT_DEPTH;

    // One result as the block reports it, field for field.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   pop_data;
        logic [LEVEL_W-1:0]  fill_level;
        logic [LEVEL_W-1:0]  peak_level;
        logic [TOTAL_W-1:0]  pushes;
        logic [TOTAL_W-1:0]  pops;
        logic [TOTAL_W-1:0]  drops;
    } t_fifo_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_kind;
    logic [DATA_W-1:0]   i_push_data;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [STATUS_W-1:0] o_status;
    logic [DATA_W-1:0]   o_pop_data;
    logic [LEVEL_W-1:0]  o_fill_level;
    logic [LEVEL_W-1:0]  o_peak_level;
    logic [TOTAL_W-1:0]  o_pushes_total;
    logic [TOTAL_W-1:0]  o_pops_total;
    logic [TOTAL_W-1:0]  o_drops_total;

    overwrite_oldest_fifo_with_stats dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_push_data    (i_push_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_pop_data     (o_pop_data),
        .o_fill_level   (o_fill_level),
        .o_peak_level   (o_peak_level),
        .o_pushes_total (o_pushes_total),
        .o_pops_total   (o_pops_total),
        .o_drops_total  (o_drops_total)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the buffer and its statistics, in the reset state.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0]  sample_ram [FIFO_DEPTH];
    int                 rd_idx      = 0;
    int                 wr_idx      = 0;
    int                 held_level  = 0;
    int                 peak_held   = 0;
    logic [TOTAL_W-1:0] exp_pushes  = '0;
    logic [TOTAL_W-1:0] exp_pops    = '0;
    logic [TOTAL_W-1:0] exp_drops   = '0;

    t_fifo_result pending_results [$];
    int           error_count   = 0;
    int           results_seen  = 0;

    // Stimulus shaping for the sender and the result sink.
    bit steady_flow   = 1'b0;   // no idling on either side while set
    int sink_hold_len = 0;      // one-shot long receiver stall, in cycles

    // Apply one push or pop to the shadow buffer and return what the block
    // must report for it.
    function automatic t_fifo_result predict_fifo_op(input logic kind,
                                                     input logic [DATA_W-1:0] word);
        t_fifo_result r;
        r.status   = ST_OK;
        r.pop_data = '0;
        if (kind == KIND_PUSH) begin
            // Full: throw away the oldest sample before storing.
            if (held_level == FIFO_DEPTH) begin
                rd_idx     = (rd_idx == FIFO_DEPTH - 1) ? 0 : rd_idx + 1;
                held_level = held_level - 1;
                exp_drops  = exp_drops + 1'b1;
                r.status   = ST_OVERFLOW;
            end
            sample_ram[wr_idx] = word;
            wr_idx     = (wr_idx == FIFO_DEPTH - 1) ? 0 : wr_idx + 1;
            held_level = held_level + 1;
            exp_pushes = exp_pushes + 1'b1;
            if (held_level > peak_held) begin
                peak_held = held_level;
            end
        end else if (held_level == 0) begin
            // Empty pop leaves everything alone.
            r.status = ST_EMPTY;
        end else begin
            r.pop_data = sample_ram[rd_idx];
            rd_idx     = (rd_idx == FIFO_DEPTH - 1) ? 0 : rd_idx + 1;
            held_level = held_level - 1;
            exp_pops   = exp_pops + 1'b1;
        end
        r.fill_level = LEVEL_W'(held_level);
        r.peak_level = LEVEL_W'(peak_held);
        r.pushes     = exp_pushes;
        r.pops       = exp_pops;
        r.drops      = exp_drops;
        return r;
    endfunction

    // Print one line per mismatch, but keep the log bounded.
    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 100) begin
            $display("mismatch at result %0d: %s", results_seen, msg);
        end
    endtask

    // Idle length in cycles: mostly none or short, now and then long.
    function automatic int idle_gap();
        int r;
        if (steady_flow) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Clock and time limit.
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Stop a hung run; the slowest legal run is far shorter than this.
    initial begin
        #5_000_000;
        $display("[overwrite_oldest_fifo_with_stats] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result sink: drive ready at the falling edge. Honor a requested long
    // hold first, else stall at random unless steady flow is on.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (sink_hold_len > 0) begin
                stall         = sink_hold_len;
                sink_hold_len = 0;
                i_out_ready   = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                stall = ($urandom_range(0, 2) == 0) ? idle_gap() : 0;
                if (stall > 0) begin
                    i_out_ready = 1'b0;
                    repeat (stall - 1) @(negedge i_clk);
                end else begin
                    i_out_ready = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: at each rising edge check a taken result against the
    // oldest expectation first, then predict for an item taken at the
    // same edge. A result never shows up at the edge its item is taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_fifo_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                flag_error("result with no item outstanding");
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    flag_error($sformatf("status got %0d want %0d", o_status, want.status));
                if (o_pop_data !== want.pop_data)
                    flag_error($sformatf("pop_data got %h want %h",
                                         o_pop_data, want.pop_data));
                if (o_fill_level !== want.fill_level)
                    flag_error($sformatf("fill_level got %0d want %0d",
                                         o_fill_level, want.fill_level));
                if (o_peak_level !== want.peak_level)
                    flag_error($sformatf("peak_level got %0d want %0d",
                                         o_peak_level, want.peak_level));
                if (o_pushes_total !== want.pushes)
                    flag_error($sformatf("pushes_total got %0d want %0d",
                                         o_pushes_total, want.pushes));
                if (o_pops_total !== want.pops)
                    flag_error($sformatf("pops_total got %0d want %0d",
                                         o_pops_total, want.pops));
                if (o_drops_total !== want.drops)
                    flag_error($sformatf("drops_total got %0d want %0d",
                                         o_drops_total, want.drops));
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            pending_results.push_back(predict_fifo_op(i_kind, i_push_data));
        end
    end

    // ------------------------------------------------------------------
    // Sender: idle for a random gap, then offer one item at the falling
    // edge and hold it until the block takes it at a rising edge.
    // ------------------------------------------------------------------
    task automatic send_op(input logic kind, input logic [DATA_W-1:0] word);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  = 1'b1;
        i_kind      = kind;
        i_push_data = word;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid and wait until every outstanding result is back, then
    // idle before returning. Bounded so a lost result cannot hang here.
    task automatic wait_for_results();
        int guard;
        guard = 0;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_results.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", pending_results.size()));
            pending_results.delete();
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Random ops with random words; pop_pct biases toward draining.
    task automatic run_random_ops(input int count, input int pop_pct);
        for (int n = 0; n < count; n++) begin
            send_op(($urandom_range(0, 99) < pop_pct) ? KIND_POP : KIND_PUSH, $urandom());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Empty pops, extreme words, and a pop right behind its push.
    task automatic test_directed_edges();
        steady_flow = 1'b1;
        send_op(KIND_POP,  32'h0000_0000);
        send_op(KIND_PUSH, 32'h0000_0000);
        send_op(KIND_PUSH, 32'hFFFF_FFFF);
        send_op(KIND_PUSH, 32'hAAAA_AAAA);
        send_op(KIND_PUSH, 32'h5555_5555);
        send_op(KIND_POP,  32'hFFFF_FFFF);
        send_op(KIND_POP,  32'h0000_0000);
        send_op(KIND_POP,  32'h0000_0000);
        send_op(KIND_POP,  32'h0000_0000);
        send_op(KIND_POP,  32'h0000_0000);
        send_op(KIND_PUSH, 32'h0000_0001);
        send_op(KIND_POP,  32'h1234_5678);
        send_op(KIND_PUSH, 32'h8000_0000);
        send_op(KIND_PUSH, 32'h7FFF_FFFF);
        send_op(KIND_POP,  32'h0000_0000);
        send_op(KIND_POP,  32'h0000_0000);
        send_op(KIND_POP,  32'h0000_0000);
        steady_flow = 1'b0;
        wait_for_results();
    endtask

    // Push hard enough to fill the buffer and overwrite many times.
    task automatic test_fill_and_overflow();
        run_random_ops(200, 10);
    endtask

    // Drain from full down to empty and poke the empty state.
    task automatic test_drain_to_empty();
        run_random_ops(150, 85);
    endtask

    // Stall the result side for a long stretch while items keep coming,
    // so the block backs up and holds off its input; then pause the
    // sender until everything is back.
    task automatic test_backpressure();
        steady_flow   = 1'b1;
        sink_hold_len = 300;
        run_random_ops(40, 40);
        steady_flow = 1'b0;
        wait_for_results();
    endtask

    // Balanced traffic, alternating stretches of full rate and idling.
    task automatic test_mixed_traffic();
        for (int blk = 0; blk < 14; blk++) begin
            steady_flow = (blk % 3 == 1);
            run_random_ops(50, (blk % 4 == 2) ? 25 : 50);
        end
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset once, run the tests, then judge the run.
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_kind      = KIND_PUSH;
        i_push_data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_edges();
        test_fill_and_overflow();
        test_drain_to_empty();
        test_backpressure();
        test_mixed_traffic();

        wait_for_results();
        repeat (10) @(posedge i_clk);

        if (error_count == 0) begin
            $display("[overwrite_oldest_fifo_with_stats] OK");
        end else begin
            $display("[overwrite_oldest_fifo_with_stats] ERROR");
        end
        $finish;
    end

endmodule

// ===== overwrite_oldest_fifo_with_stats.f =====
rtl/core/owf_pkg.sv
rtl/core/owf_store.sv
rtl/core/owf_ctrl.sv
rtl/core/overwrite_oldest_fifo_with_stats.sv
rtl/core/owf_checker.sv
verif/tb_overwrite_oldest_fifo_with_stats.sv
